// ===== rtl/bctc_pkg.sv =====
`timescale 1ns / 1ps
package bctc_pkg;

    localparam int SLOT_W  = 6;
    localparam int BLOCK_W = 32;
    localparam int STAMP_W = 32;

    typedef enum logic [1:0] {
        CMD_READ     = 2'd0,
        CMD_WRITE    = 2'd1,
        CMD_UNCACHED = 2'd2,
        CMD_FLUSH    = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        K_READY = 2'd0,
        K_FILL  = 2'd1,
        K_WBACK = 2'd2,
        K_DONE  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        SCAN_LOOK  = 2'd0,
        SCAN_ALL   = 2'd1,
        SCAN_MATCH = 2'd2
    } t_scan_mode;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'd0,
        ST_LOOK   = 3'd1,
        ST_DECIDE = 3'd2,
        ST_WBACK  = 3'd3,
        ST_UPD    = 3'd4,
        ST_FIN    = 3'd5
    } t_state;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        t_scan_mode scan_mode;
        logic       commit;
        logic       done;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic hit;
        logic have_clean;
        logic any_dirty;
    } t_dp_stat;

endpackage

// ===== rtl/bctc_ram.sv =====
`timescale 1ns / 1ps
module bctc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/bctc_datapath.sv =====
`timescale 1ns / 1ps
module bctc_datapath import bctc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_ctl,
    input  logic [1:0]         i_req_cmd,
    input  logic [BLOCK_W-1:0] i_block,
    input  logic               i_partial,
    input  logic [STAMP_W-1:0] i_now,
    output t_dp_stat           o_stat,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [BLOCK_W-1:0] o_block_out,
    output logic               o_last
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // request
    logic [BLOCK_W-1:0] r_blk;
    logic [STAMP_W-1:0] r_now;
    logic               r_partial;
    logic               r_is_write;

    // scan engine
    t_scan_mode         r_mode;
    logic               r_issue;
    logic               r_pend;
    logic [IW-1:0]      r_raddr;
    logic [IW-1:0]      r_pidx;

    // lookup results
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic               r_have_clean;
    logic [IW-1:0]      r_clean_idx;
    logic [STAMP_W-1:0] r_clean_stamp;
    logic [IW-1:0]      r_all_idx;
    logic [STAMP_W-1:0] r_all_stamp;

    // per-slot state
    logic [ENTRIES-1:0] r_written;
    logic [ENTRIES-1:0] r_valid;
    logic [ENTRIES-1:0] r_dirty;
    logic               r_any_dirty;

    // result register
    logic               r_o_valid;
    t_kind              r_o_kind;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [BLOCK_W-1:0] r_o_block;
    logic               r_o_last;

    logic [BLOCK_W-1:0] tag_rd;
    logic [STAMP_W-1:0] stamp_rd;
    logic [BLOCK_W-1:0] eff_tag;
    logic [STAMP_W-1:0] eff_stamp;
    logic               tag_eq;
    logic               hit_now;
    logic               scan_done;
    logic               clean_take;
    logic               all_take;
    logic               wb_emit;
    logic [IW-1:0]      sel_idx;
    logic               keep_valid;
    logic               need_fill;

    bctc_ram #(.WIDTH(BLOCK_W), .DEPTH(ENTRIES)) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit),
        .i_waddr (sel_idx),
        .i_wdata (r_blk),
        .i_raddr (r_raddr),
        .o_rdata (tag_rd)
    );

    bctc_ram #(.WIDTH(STAMP_W), .DEPTH(ENTRIES)) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.commit),
        .i_waddr (sel_idx),
        .i_wdata (r_now),
        .i_raddr (r_raddr),
        .o_rdata (stamp_rd)
    );

    // a slot never written reads as tag zero and stamp zero
    assign eff_tag   = r_written[r_pidx] ? tag_rd : '0;
    assign eff_stamp = r_written[r_pidx] ? stamp_rd : '0;
    assign tag_eq    = (eff_tag == r_blk);

    assign hit_now    = r_pend && (r_mode == SCAN_LOOK) && tag_eq;
    assign scan_done  = r_pend && ((r_pidx == LAST_IDX) || hit_now);
    assign clean_take = r_pend && (r_mode == SCAN_LOOK) && !r_dirty[r_pidx]
                        && (!r_have_clean || (eff_stamp < r_clean_stamp));
    assign all_take   = r_pend && (r_mode == SCAN_LOOK)
                        && ((r_pidx == '0) || (eff_stamp < r_all_stamp));
    assign wb_emit    = r_pend && (r_mode != SCAN_LOOK) && r_dirty[r_pidx]
                        && ((r_mode == SCAN_ALL) || tag_eq);

    assign sel_idx    = r_hit ? r_hit_idx : (r_have_clean ? r_clean_idx : r_all_idx);
    assign keep_valid = r_hit && r_valid[sel_idx];
    assign need_fill  = !keep_valid && (!r_is_write || r_partial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= SCAN_LOOK;
            r_issue      <= 1'b0;
            r_pend       <= 1'b0;
            r_hit        <= 1'b0;
            r_have_clean <= 1'b0;
            r_written    <= '0;
            r_valid      <= '0;
            r_dirty      <= '0;
            r_any_dirty  <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_o_valid <= 1'b0;
            if (i_ctl.scan_start) begin
                r_mode       <= i_ctl.scan_mode;
                r_issue      <= 1'b1;
                r_pend       <= 1'b0;
                r_hit        <= 1'b0;
                r_have_clean <= 1'b0;
            end else begin
                if (r_issue) begin
                    r_pend <= 1'b1;
                    if (r_raddr == LAST_IDX) begin
                        r_issue <= 1'b0;
                    end
                end else begin
                    r_pend <= 1'b0;
                end
                // first matching slot ends the lookup
                if (hit_now) begin
                    r_issue <= 1'b0;
                    r_pend  <= 1'b0;
                    r_hit   <= 1'b1;
                end
                if (clean_take) begin
                    r_have_clean <= 1'b1;
                end
                if (wb_emit) begin
                    r_dirty[r_pidx] <= 1'b0;
                    r_o_valid       <= 1'b1;
                end
                if (scan_done && (r_mode == SCAN_ALL)) begin
                    r_any_dirty <= 1'b0;
                end
            end
            if (i_ctl.commit) begin
                r_written[sel_idx] <= 1'b1;
                r_valid[sel_idx]   <= keep_valid || need_fill || r_is_write;
                if (r_is_write) begin
                    r_dirty[sel_idx] <= 1'b1;
                    r_any_dirty      <= 1'b1;
                end
                r_o_valid <= 1'b1;
            end
            if (i_ctl.done) begin
                r_o_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_blk      <= i_block;
            r_now      <= i_now;
            r_partial  <= i_partial;
            r_is_write <= (t_cmd'(i_req_cmd) == CMD_WRITE);
        end
        if (i_ctl.scan_start) begin
            r_raddr <= '0;
        end else if (r_issue && (r_raddr != LAST_IDX)) begin
            r_raddr <= r_raddr + IW'(1);
        end
        if (r_issue) begin
            r_pidx <= r_raddr;
        end
        if (hit_now) begin
            r_hit_idx <= r_pidx;
        end
        if (clean_take) begin
            r_clean_idx   <= r_pidx;
            r_clean_stamp <= eff_stamp;
        end
        if (all_take) begin
            r_all_idx   <= r_pidx;
            r_all_stamp <= eff_stamp;
        end
        if (wb_emit) begin
            r_o_kind  <= K_WBACK;
            r_o_slot  <= SLOT_W'(r_pidx);
            r_o_block <= eff_tag;
            r_o_last  <= 1'b0;
        end else if (i_ctl.commit) begin
            r_o_kind  <= need_fill ? K_FILL : K_READY;
            r_o_slot  <= SLOT_W'(sel_idx);
            r_o_block <= need_fill ? r_blk : '0;
            r_o_last  <= 1'b1;
        end else if (i_ctl.done) begin
            r_o_kind  <= K_DONE;
            r_o_slot  <= '0;
            r_o_block <= '0;
            r_o_last  <= 1'b1;
        end
    end

    assign o_stat.scan_done  = scan_done;
    assign o_stat.hit        = r_hit;
    assign o_stat.have_clean = r_have_clean;
    assign o_stat.any_dirty  = r_any_dirty;

    assign o_valid     = r_o_valid;
    assign o_kind      = r_o_kind;
    assign o_slot      = r_o_slot;
    assign o_block_out = r_o_block;
    assign o_last      = r_o_last;

    a_last_marks_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_last == (r_o_kind != K_WBACK)))
        else $error("last flag disagrees with result kind");

    a_start_when_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.scan_start |-> (!r_issue && !r_pend))
        else $error("scan started while another scan runs");

    a_commit_no_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.commit |-> (!r_issue && !r_pend))
        else $error("tag write during a scan");

    a_write_sets_dirty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.commit && r_is_write) |=> (r_any_dirty && r_dirty[$past(sel_idx)]))
        else $error("cached write left the slot clean");

endmodule

// ===== rtl/bctc_controller.sv =====
`timescale 1ns / 1ps
module bctc_controller import bctc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_cmd,
    input  t_dp_stat   i_stat,
    output t_dp_cmd    o_ctl,
    output logic       o_busy
);

    t_state r_state;
    t_state n_state;
    t_cmd   r_req;
    logic   req_cached;
    logic   new_cached;

    assign req_cached = (r_req == CMD_READ) || (r_req == CMD_WRITE);
    assign new_cached = (t_cmd'(i_cmd) == CMD_READ) || (t_cmd'(i_cmd) == CMD_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_req   <= CMD_READ;
        end else begin
            r_state <= n_state;
            if ((r_state == ST_IDLE) && i_start) begin
                r_req <= t_cmd'(i_cmd);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (new_cached) begin
                        n_state = ST_LOOK;
                    end else if (i_stat.any_dirty) begin
                        n_state = ST_WBACK;
                    end else begin
                        n_state = ST_FIN;
                    end
                end
            end
            ST_LOOK: begin
                if (i_stat.scan_done) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                n_state = (i_stat.hit || i_stat.have_clean) ? ST_UPD : ST_WBACK;
            end
            ST_WBACK: begin
                if (i_stat.scan_done) begin
                    n_state = req_cached ? ST_UPD : ST_FIN;
                end
            end
            ST_UPD:  n_state = ST_IDLE;
            ST_FIN:  n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_ctl = '{load: 1'b0, scan_start: 1'b0, scan_mode: SCAN_LOOK,
                  commit: 1'b0, done: 1'b0};
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    if (new_cached) begin
                        o_ctl.scan_start = 1'b1;
                        o_ctl.scan_mode  = SCAN_LOOK;
                    end else if (i_stat.any_dirty) begin
                        o_ctl.scan_start = 1'b1;
                        o_ctl.scan_mode  = (t_cmd'(i_cmd) == CMD_FLUSH) ? SCAN_ALL
                                                                         : SCAN_MATCH;
                    end
                end
            end
            ST_DECIDE: begin
                // no clean slot: write back everything before picking a victim
                if (!(i_stat.hit || i_stat.have_clean)) begin
                    o_ctl.scan_start = 1'b1;
                    o_ctl.scan_mode  = SCAN_ALL;
                end
            end
            ST_UPD:  o_ctl.commit = 1'b1;
            ST_FIN:  o_ctl.done = 1'b1;
            default: o_ctl.done = 1'b0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

// ===== rtl/block_cache_tag_controller_core.sv =====
`timescale 1ns / 1ps
// Tag and replacement controller for a fully associative write-back block cache.
// Request channel: a request (i_cmd, i_block, i_partial, i_now) transfers at a
// rising edge with start high and busy low; busy stays high until the last result
// of that request has been registered.
// Result channel: each result (o_kind, o_slot, o_block_out, o_last) is shown for
// one cycle with o_valid high; o_last marks the final result of a request. The
// receiver cannot stall, so results leave at one per cycle as they are found.
// Timing: a scan reads tag and stamp memories one slot per cycle through
// one read port. A hit ends the scan at the matching slot; a miss with a clean
// victim scans every slot, and a miss with no clean slot adds a write-back pass
// over all slots. Uncached access and flush scan only when any slot is dirty.
// A new request may start in the cycle after the final result is registered.
// Reset: synchronous, active low; all slots read as tag 0, stamp 0, no data,
// clean. Per-slot written bits stand in for the memory contents, so there is no
// clearing pass.
module block_cache_tag_controller_core import bctc_pkg::*; #(
    parameter int ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_cmd,
    input  logic [BLOCK_W-1:0] i_block,
    input  logic               i_partial,
    input  logic [STAMP_W-1:0] i_now,
    output logic               o_valid,
    output logic [1:0]         o_kind,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [BLOCK_W-1:0] o_block_out,
    output logic               o_last
);

    t_dp_cmd  ctl;
    t_dp_stat stat;

    bctc_controller u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_stat  (stat),
        .o_ctl   (ctl),
        .o_busy  (busy)
    );

    bctc_datapath #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_req_cmd   (i_cmd),
        .i_block     (i_block),
        .i_partial   (i_partial),
        .i_now       (i_now),
        .o_stat      (stat),
        .o_valid     (o_valid),
        .o_kind      (o_kind),
        .o_slot      (o_slot),
        .o_block_out (o_block_out),
        .o_last      (o_last)
    );

endmodule
